// ===== hw/rtl/mbps_pkg.sv =====
`default_nettype none

package mbps_pkg;

  // Store depth and byte counter width
  localparam int PATTERN_MAX = 64;
  localparam int COUNT_WIDTH = 32;

  // Fixed field widths
  localparam int IDX_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int CFG_LEN_W = 7;
  localparam int ADDR_W    = 64;
  localparam int CFG_W     = 64;

  // Derived widths
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int WIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int DIFF_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  typedef enum logic [0:0] {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_BASE_ADDRESS   = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_WRITE_PATTERN = 1'b0,
    OP_SCAN_BYTE     = 1'b1
  } op_t;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  pattern_index;
    logic [BYTE_W-1:0] pattern_byte;
    logic              care;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
    logic              region_end;
  } out_t;

  // Write request into the pattern and care stores
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] pattern_byte;
    logic              care;
  } pat_wr_t;

  typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] byte_vec_t;

  // Clamp the programmed length into 1..PATTERN_MAX
  function automatic logic [LEN_W-1:0] active_len(input logic [CFG_LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    if (raw == '0) begin
      len = LEN_W'(1);
    end else if (int'(raw) > PATTERN_MAX) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = LEN_W'(raw);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbps_pattern_store.sv =====
`default_nettype none

module mbps_pattern_store (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mbps_pkg::pat_wr_t wr,
  output mbps_pkg::byte_vec_t    pattern,
  output logic [mbps_pkg::PATTERN_MAX-1:0] care
);
  import mbps_pkg::*;

  // One register per position; a write to an index past the store is dropped
  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_entry
    always_ff @(posedge clk) begin
      if (wr.en && int'(wr.idx) == p) begin
        pattern[p] <= wr.pattern_byte;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        care[p] <= 1'b0;
      end else if (wr.en && int'(wr.idx) == p) begin
        care[p] <= wr.care;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbps_window.sv =====
`default_nettype none

module mbps_window (
  input  wire logic                        clk,
  input  wire logic                        shift_en,
  input  wire logic [mbps_pkg::BYTE_W-1:0] data_byte,
  output mbps_pkg::byte_vec_t              view
);
  import mbps_pkg::*;

  byte_vec_t window;

  // View after the incoming byte is shifted in; entry 0 is the newest byte
  assign view[0] = data_byte;
  for (genvar i = 1; i < PATTERN_MAX; i++) begin : g_view
    assign view[i] = window[i-1];
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      window <= view;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbps_compare.sv =====
`default_nettype none

module mbps_compare (
  input  wire mbps_pkg::byte_vec_t                pattern,
  input  wire logic [mbps_pkg::PATTERN_MAX-1:0]   care,
  input  wire mbps_pkg::byte_vec_t                window,
  input  wire logic [mbps_pkg::LEN_W-1:0]         len,
  output logic                                    match
);
  import mbps_pkg::*;

  logic [PATTERN_MAX-1:0] ok;

  // Pattern position p lines up with window entry len-1-p
  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_pos
    localparam logic [LEN_W-1:0] POS = LEN_W'(p);
    logic             in_use;
    logic [LEN_W-1:0] sel;

    assign in_use = POS < len;
    assign sel    = len - POS - LEN_W'(1);
    assign ok[p]  = !in_use || !care[p] || (window[sel[WIDX_W-1:0]] == pattern[p]);
  end

  assign match = &ok;

endmodule

`default_nettype wire

// ===== hw/rtl/masked_byte_pattern_search_top.sv =====
// Masked byte pattern search.
// Requests arrive on the in channel (valid/ready). A request with op set to
// write pattern stores one pattern byte and its care bit; a request with op
// set to scan feeds the next byte of the region, with last on its final byte.
// A scan request gives at most one result on the out channel: the first match
// of the region (found 1, base address plus start offset), or, when the region
// ends with no match, a not-found result with region_end set.
// Configuration (pattern length, base address) is written through cfg_we,
// cfg_index and cfg_data while the block is idle; a write takes effect at once.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle while the receiver does not stall; compare,
// count and address add sit between the single input and result registers.
// Synchronous reset clears the care bits, byte count, match flag and the valid
// flags, and sets pattern length to one and base address to zero; pattern bytes
// stay unknown until written.
// When the receiver stalls, the result register holds; a full input register
// then holds its request and ready drops until the result is taken.
`default_nettype none

module masked_byte_pattern_search_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mbps_pkg::in_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output mbps_pkg::out_t                  out_data,
  input  wire logic                       cfg_we,
  input  wire mbps_pkg::cfg_reg_t         cfg_index,
  input  wire logic [mbps_pkg::CFG_W-1:0] cfg_data
);
  import mbps_pkg::*;

  // Configuration registers
  logic [CFG_LEN_W-1:0] pattern_length;
  logic [ADDR_W-1:0]    base_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= CFG_LEN_W'(1);
      base_address   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[CFG_LEN_W-1:0];
        CFG_BASE_ADDRESS:   base_address   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic s1_valid;
  in_t  s1_data;
  logic s1_adv;
  logic fire;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign fire     = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  logic is_scan;
  assign is_scan = (op_t'(s1_data.op) == OP_SCAN_BYTE);

  // Pattern and care stores
  pat_wr_t                pat_wr;
  byte_vec_t              pattern;
  logic [PATTERN_MAX-1:0] care;

  assign pat_wr.en           = fire && !is_scan;
  assign pat_wr.idx          = s1_data.pattern_index;
  assign pat_wr.pattern_byte = s1_data.pattern_byte;
  assign pat_wr.care         = s1_data.care;

  mbps_pattern_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (pat_wr),
    .pattern (pattern),
    .care    (care)
  );

  // Sliding window; the compare sees it with this byte already shifted in
  byte_vec_t window_view;

  mbps_window u_window (
    .clk       (clk),
    .shift_en  (fire && is_scan),
    .data_byte (s1_data.data_byte),
    .view      (window_view)
  );

  logic [LEN_W-1:0] len;
  logic             window_hit;

  assign len = active_len(pattern_length);

  mbps_compare u_compare (
    .pattern (pattern),
    .care    (care),
    .window  (window_view),
    .len     (len),
    .match   (window_hit)
  );

  // Byte count and match flag for the current region
  logic [COUNT_WIDTH-1:0] byte_count;
  logic [COUNT_WIDTH-1:0] byte_count_next;
  logic                   match_seen;
  logic                   hit;
  logic                   has_result;
  logic [DIFF_W-1:0]      offset;
  out_t                   result;

  always_comb begin
    // Saturate rather than wrap
    byte_count_next = (byte_count != '1) ? byte_count + COUNT_WIDTH'(1) : byte_count;
    hit = !match_seen && (DIFF_W'(byte_count_next) >= DIFF_W'(len)) && window_hit;
    has_result = is_scan && (hit || (s1_data.last && !match_seen));
    offset = DIFF_W'(byte_count_next) - DIFF_W'(len);
    result.found         = hit;
    result.match_address = hit ? base_address + ADDR_W'(offset) : '0;
    result.region_end    = s1_data.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      match_seen <= 1'b0;
    end else if (fire && is_scan) begin
      if (s1_data.last) begin
        // Region ends: drop count and flag, keep the window
        byte_count <= '0;
        match_seen <= 1'b0;
      end else begin
        byte_count <= byte_count_next;
        if (hit) begin
          match_seen <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbps_checker.sv =====
`default_nettype none

module mbps_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire mbps_pkg::out_t out_data
);
  import mbps_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A not-found result only comes at region end, with a zero address
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.region_end && out_data.match_address == '0)
    else $error("malformed not-found result");

  // With no result waiting, requests are always taken
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty result register");

  // Reset leaves no result behind
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind masked_byte_pattern_search_top mbps_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_masked_byte_pattern_search_top.sv =====
`default_nettype none

// Testbench for the masked byte pattern search block.
// Requests are queued by the stimulus process, pushed into the block by a
// clocked driver and mirrored into a behavioural search model at the edge
// at which the block takes them. A clocked monitor pops the oldest expected
// outcome for every result the block hands over and compares it field by field.
module tb_masked_byte_pattern_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbps_pkg::*;

  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off for back-pressure
  localparam int CYCLE_LIMIT  = 200000;  // generous ceiling on the whole run
  localparam int DRAIN_CYCLES = 8;       // settle time once nothing is outstanding
  localparam int PHASE_BUDGET = 56;      // scan and noise requests per random phase
  localparam int NUM_PHASES   = 7;
  localparam int MAX_REPORTS  = 50;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH,
    IDLE_HOLD
  } idle_mode_t;

  // Block ports; every input starts at a known value
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we    = 1'b0;
  cfg_reg_t          cfg_index = CFG_PATTERN_LENGTH;
  logic [CFG_W-1:0]  cfg_data  = '0;

  // Requests waiting to be driven, and outcomes the block still owes us
  in_t  pending_reqs[$];
  out_t expected_outcomes[$];

  // Search model state, mirroring the block from reset onwards
  bit [BYTE_W-1:0]      pat_bytes [PATTERN_MAX];
  bit                   care_bits [PATTERN_MAX];
  bit [BYTE_W-1:0]      window    [PATTERN_MAX];  // entry 0 holds the newest byte
  bit [COUNT_WIDTH-1:0] scan_count = '0;
  bit                   match_flag = 1'b0;
  bit [CFG_LEN_W-1:0]   len_reg    = CFG_LEN_W'(1);
  bit [ADDR_W-1:0]      base_reg   = '0;

  // Pattern as the stimulus side has loaded it, used to plant matches
  bit [BYTE_W-1:0] gen_pat  [PATTERN_MAX];
  bit              gen_care [PATTERN_MAX];
  int              items_made = 0;

  // Idling knobs, changed only at a falling edge
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  bit hold_on        = 1'b0;
  int hold_cnt       = 0;

  int err_count   = 0;
  int cycle_count = 0;

  masked_byte_pattern_search_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Search model: apply one accepted request, queue the outcome it causes
  // ---------------------------------------------------------------------------
  task automatic search_step(input in_t req);
    int   len;
    int   i;
    bit   hit;
    out_t res;
    if (req.op == OP_WRITE_PATTERN) begin
      // Pattern load: byte and care bit go in together, no outcome
      pat_bytes[req.pattern_index] = req.pattern_byte;
      care_bits[req.pattern_index] = req.care;
    end else begin
      // Shift the window and count the byte, saturating the count
      for (i = PATTERN_MAX - 1; i > 0; i--) begin
        window[i] = window[i-1];
      end
      window[0] = req.data_byte;
      if (scan_count != '1) begin
        scan_count++;
      end
      // Clamp the programmed length: zero acts as one, oversize as the store depth
      if (len_reg == 0) begin
        len = 1;
      end else if (len_reg > PATTERN_MAX) begin
        len = PATTERN_MAX;
      end else begin
        len = int'(len_reg);
      end
      // Compare the first len window entries; wildcard positions always agree
      hit = !match_flag && (scan_count >= len);
      for (i = 0; i < len && hit; i++) begin
        if (care_bits[i] && window[len-1-i] != pat_bytes[i]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        res.found         = 1'b1;
        res.match_address = base_reg + ADDR_W'(scan_count) - ADDR_W'(len);
        res.region_end    = req.last;
        expected_outcomes.push_back(res);
        match_flag = 1'b1;
      end else if (req.last && !match_flag) begin
        // Region closed without a match
        res            = '0;
        res.region_end = 1'b1;
        expected_outcomes.push_back(res);
      end
      if (req.last) begin
        scan_count = '0;
        match_flag = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_outcomes.size() == 0) begin
      report_mismatch($sformatf("unexpected result found=%0d addr=%h end=%0d",
                                got.found, got.match_address, got.region_end));
      return;
    end
    want = expected_outcomes.pop_front();
    if (got.found !== want.found) begin
      report_mismatch($sformatf("found got %0d want %0d", got.found, want.found));
    end
    if (got.match_address !== want.match_address) begin
      report_mismatch($sformatf("match_address got %h want %h",
                                got.match_address, want.match_address));
    end
    if (got.region_end !== want.region_end) begin
      report_mismatch($sformatf("region_end got %0d want %0d",
                                got.region_end, want.region_end));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hand over the next request when the slot is free, model on accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        search_step(in_data);
      end
      // Hold the current request until taken; only then offer or idle
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count the long hold-off in its own process
  always @(posedge clk) begin
    if (rst || !hold_on) begin
      hold_cnt <= 0;
    end else if (hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check every result taken, then choose the next ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
      end
      if (hold_on && hold_cnt < HOLD_CYCLES) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Drop out if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; all called at a falling edge
  // ---------------------------------------------------------------------------
  task automatic push_write(input int idx, input logic [7:0] pbyte, input bit pcare);
    in_t req;
    req.op            = OP_WRITE_PATTERN;
    req.pattern_index = IDX_W'(idx);
    req.pattern_byte  = pbyte;
    req.care          = pcare;
    req.data_byte     = BYTE_W'($urandom);       // ignored on a load
    req.last          = 1'($urandom_range(1));   // ignored on a load
    pending_reqs.push_back(req);
    gen_pat[idx]  = pbyte;
    gen_care[idx] = pcare;
    items_made++;
  endtask

  task automatic push_scan(input logic [7:0] dbyte, input bit is_last);
    in_t req;
    req.op            = OP_SCAN_BYTE;
    req.pattern_index = IDX_W'($urandom);    // load fields are noise here
    req.pattern_byte  = BYTE_W'($urandom);
    req.care          = 1'($urandom_range(1));
    req.data_byte     = dbyte;
    req.last          = is_last;
    pending_reqs.push_back(req);
    items_made++;
  endtask

  // One region; a planted match copies the cared-for pattern bytes in place
  task automatic push_region(input int plen, input int nbytes, input bit plant);
    int          at;
    int          i;
    int          p;
    logic [7:0]  b;
    at = plant ? $urandom_range(nbytes - plen, 0) : -1;
    for (i = 0; i < nbytes; i++) begin
      p = i - at;
      // Bias bytes towards pattern contents so chance matches happen too
      if ($urandom_range(3) == 0) begin
        b = BYTE_W'($urandom);
      end else begin
        b = gen_pat[$urandom_range(plen - 1)];
      end
      if (plant && p >= 0 && p < plen && gen_care[p]) begin
        b = gen_pat[p];
      end
      // Now and then slip a pattern load into the region
      if ($urandom_range(99) < 4) begin
        push_write($urandom_range(PATTERN_MAX - 1), BYTE_W'($urandom),
                   1'($urandom_range(1)));
      end
      push_scan(b, i == nbytes - 1);
    end
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_PATTERN_LENGTH) begin
      len_reg = val[CFG_LEN_W-1:0];
    end else begin
      base_reg = val;
    end
  endtask

  task automatic cfg_pair(input logic [CFG_W-1:0] plen, input logic [CFG_W-1:0] base);
    cfg_write(CFG_PATTERN_LENGTH, plen);
    cfg_write(CFG_BASE_ADDRESS, base);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until everything queued has gone in and every outcome has come out
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_outcomes.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    hold_on = 1'b0;
    case (mode)
      IDLE_NONE: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_gap_pct   = 49;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_gap_pct   = 0;
        recv_stall_pct = 49;
      end
      IDLE_BOTH: begin
        send_gap_pct   = 15;
        recv_stall_pct = 15;
      end
      IDLE_HOLD: begin
        // Receiver holds off while the sender keeps offering requests
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_on        = 1'b1;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    idle_mode_t       modes [NUM_PHASES];
    logic [CFG_W-1:0] lens  [NUM_PHASES];
    logic [CFG_W-1:0] base;
    int               ph;
    int               plen;
    int               care_pct;
    int               start;
    int               i;
    int               nbytes;
    bit               plant;

    modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD, IDLE_BOTH, IDLE_SEND};
    lens  = '{64, 5, 0, 127, 3, 2, 0};
    lens[NUM_PHASES-1] = CFG_W'($urandom_range(8, 1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: three-byte pattern with a wildcard in the middle
    cfg_pair(3, 64'h1000);
    set_idle(IDLE_NONE);
    push_write(0, 8'h00, 1'b1);
    push_write(1, 8'hFF, 1'b0);
    push_write(2, 8'hFF, 1'b1);
    push_write(PATTERN_MAX - 1, 8'hAA, 1'b0);
    // Too few bytes at first, then a match mid-region, then silence to the end
    push_scan(8'h00, 1'b0);
    push_scan(8'h11, 1'b0);
    push_scan(8'hFF, 1'b0);
    push_scan(8'h00, 1'b0);
    push_scan(8'h00, 1'b1);
    // Match landing on the last byte
    push_scan(8'h00, 1'b0);
    push_scan(8'h55, 1'b0);
    push_scan(8'hFF, 1'b1);
    // Region closes without a match, and a region shorter than the pattern
    push_scan(8'h12, 1'b0);
    push_scan(8'h34, 1'b1);
    push_scan(8'hFF, 1'b1);
    wait_idle();

    // Length zero acts as one; address wraps past the top of the space
    cfg_pair(0, '1);
    push_scan(8'h7F, 1'b0);
    push_scan(8'h00, 1'b1);

    // Random phases, each with its own settings and idling
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       base = '0;
        1:       base = '1;
        3:       base = '1 - CFG_W'($urandom_range(40));
        default: base = {$urandom, $urandom};
      endcase
      cfg_pair(lens[ph], base);
      set_idle(modes[ph]);

      if (lens[ph] == 0) begin
        plen = 1;
      end else if (lens[ph] > PATTERN_MAX) begin
        plen = PATTERN_MAX;
      end else begin
        plen = int'(lens[ph]);
      end
      case (ph)
        0:       care_pct = 100;
        5:       care_pct = 0;     // all wildcards
        2:       care_pct = 50;
        default: care_pct = 75;
      endcase
      for (i = 0; i < plen; i++) begin
        push_write(i, BYTE_W'($urandom), $urandom_range(99) < care_pct);
      end

      start = items_made;
      while (items_made - start < PHASE_BUDGET) begin
        nbytes = $urandom_range(plen + (plen < 8 ? 10 : 16), 1);
        plant  = ($urandom_range(99) < 60);
        if (plant && nbytes < plen) begin
          nbytes = plen + $urandom_range(4);
        end
        push_region(plen, nbytes, plant);
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
